@@ rtl/dwhl_pkg.sv @@
// Shared types and constants for the distance-weighted hinge loss block.
// Used by every module of the block; depends on nothing else.
package dwhl_pkg;

    localparam int MAX_CLASSES  = 16;
    localparam int POS_W        = (MAX_CLASSES > 2) ? $clog2(MAX_CLASSES) : 1;
    localparam int CNT_W        = (POS_W + 1 > 5) ? POS_W + 1 : 5;
    localparam int LBL_W        = (POS_W > 4) ? POS_W : 4;
    localparam int WIDX_W       = 4;
    localparam int WEIGHT_DEPTH = 16;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = 2;

    // 1.0 in Q16.16, extended to the margin width.
    localparam logic signed [33:0] ONE_Q16 = 34'sd65536;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_SCORE = 1'b1;

    typedef enum logic [2:0] {
        CFG_NORM_MODE  = 3'd0,
        CFG_CLASSES    = 3'd1,
        CFG_GRAD_SCALE = 3'd2,
        CFG_LOSS_SCALE = 3'd3,
        CFG_GRAD_ON    = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL1,
        BK_MUL2,
        BK_COST,
        BK_SUM,
        BK_LOSS,
        BK_OUT
    } back_state_t;

    typedef struct packed {
        logic               norm_mode;
        logic [4:0]         classes_in_use;
        logic signed [31:0] gradient_scale;
        logic [16:0]        loss_scale;
        logic               gradient_on;
    } cfg_t;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] score;
        logic [3:0]         true_class;
        logic [3:0]         weight_index;
        logic [17:0]        weight_value;
        logic               batch_end;
    } item_t;

    typedef struct packed {
        logic signed [31:0] element_cost;
        logic signed [31:0] element_gradient;
        logic signed [47:0] batch_loss;
        logic               batch_done;
    } result_t;

    // One classified score on its way from the front end to the back end.
    typedef struct packed {
        logic        on_label;
        logic        positive;
        logic [31:0] margin;
        logic [17:0] weight;
        logic        batch_end;
    } work_t;

endpackage

@@ rtl/distance_weighted_hinge_loss.sv @@
// A score item passes through the back-end sequencer: one state takes it
// from the queue, five multiply and add steps follow, and a last state loads
// the result register, waiting while it is full and not taken. No new score
// is taken until then. A weight load item is written in the front end and
// returns no result. The front end keeps accepting items while the four-entry
// queue has room, and the result register holds a finished item while the next
// one is computed. Configuration writes are always accepted.
// Top level: configuration registers, front end, queue and back end.
// Depends on dwhl_pkg, dwhl_front, dwhl_queue and dwhl_back.
module distance_weighted_hinge_loss (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic              req_valid,
    output logic              req_ready,
    input  dwhl_pkg::item_t   req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output dwhl_pkg::result_t rsp
);
    import dwhl_pkg::*;

    cfg_t  cfg_reg;
    logic  push_valid;
    logic  push_ready;
    work_t push_data;
    logic  pop_valid;
    logic  pop_ready;
    work_t pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.norm_mode      <= 1'b0;
            cfg_reg.classes_in_use <= 5'd16;
            cfg_reg.gradient_scale <= 32'sd65536;
            cfg_reg.loss_scale     <= 17'd65536;
            cfg_reg.gradient_on    <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_NORM_MODE:  cfg_reg.norm_mode      <= cfg_data[0];
                CFG_CLASSES:    cfg_reg.classes_in_use <= cfg_data[4:0];
                CFG_GRAD_SCALE: cfg_reg.gradient_scale <= cfg_data;
                CFG_LOSS_SCALE: cfg_reg.loss_scale     <= cfg_data[16:0];
                CFG_GRAD_ON:    cfg_reg.gradient_on    <= cfg_data[0];
                default:        cfg_reg                <= cfg_reg;
            endcase
        end
    end

    dwhl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    dwhl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    dwhl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

endmodule

@@ rtl/dwhl_front.sv @@
// Front end: accepts items, keeps the weight table and the class counter,
// and classifies each score into a work item. Depends on dwhl_pkg.
module dwhl_front (
    input  logic            clk,
    input  logic            rst_n,
    input  dwhl_pkg::cfg_t  cfg,
    input  logic            req_valid,
    output logic            req_ready,
    input  dwhl_pkg::item_t req,
    output logic            push_valid,
    input  logic            push_ready,
    output dwhl_pkg::work_t push_data
);
    import dwhl_pkg::*;

    logic [17:0]        weight_mem [WEIGHT_DEPTH];
    logic [17:0]        weight_rd_reg;
    logic               stage_valid_reg;
    logic               stage_valid_next;
    logic               on_label_reg;
    logic               positive_reg;
    logic [31:0]        margin_reg;
    logic               batch_end_reg;
    logic [POS_W-1:0]   class_pos_reg;
    logic [POS_W-1:0]   class_pos_next;

    logic [CNT_W-1:0]   ci_ext;
    logic [CNT_W-1:0]   count;
    logic [POS_W-1:0]   pos;
    logic [CNT_W-1:0]   pos_inc;
    logic [LBL_W-1:0]   pos_x;
    logic [LBL_W-1:0]   lab_x;
    logic [LBL_W-1:0]   dist_full;
    logic [WIDX_W-1:0]  dist_idx;
    logic               on_label;
    logic signed [33:0] score_x;
    logic signed [33:0] margin;
    logic               accept;
    logic               score_acc;
    logic               load_acc;

    assign accept    = req_valid && req_ready;
    assign score_acc = accept && (req.opcode == OP_SCORE);
    assign load_acc  = accept && (req.opcode == OP_LOAD);
    assign req_ready = !stage_valid_reg || push_ready;

    always_comb
    begin
        ci_ext = CNT_W'(cfg.classes_in_use);
        if (ci_ext < CNT_W'(2))
            count = CNT_W'(2);
        else if (ci_ext > CNT_W'(MAX_CLASSES))
            count = CNT_W'(MAX_CLASSES);
        else
            count = ci_ext;

        // A counter left beyond a smaller class count starts over.
        pos     = (CNT_W'(class_pos_reg) >= count) ? '0 : class_pos_reg;
        pos_inc = CNT_W'(pos) + CNT_W'(1);
        if (req.batch_end || (pos_inc >= count))
            class_pos_next = '0;
        else
            class_pos_next = pos_inc[POS_W-1:0];

        pos_x     = LBL_W'(pos);
        lab_x     = LBL_W'(req.true_class);
        on_label  = (pos_x == lab_x);
        dist_full = (pos_x > lab_x) ? (pos_x - lab_x) : (lab_x - pos_x);
        dist_idx  = dist_full[WIDX_W-1:0];

        score_x = 34'(req.score);
        margin  = on_label ? (ONE_Q16 + score_x) : (ONE_Q16 - score_x);

        if (score_acc)
            stage_valid_next = 1'b1;
        else if (push_ready)
            stage_valid_next = 1'b0;
        else
            stage_valid_next = stage_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            class_pos_reg   <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            if (score_acc)
                class_pos_reg <= class_pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_acc)
            weight_mem[req.weight_index] <= req.weight_value;
        if (score_acc)
        begin
            weight_rd_reg <= weight_mem[dist_idx];
            on_label_reg  <= on_label;
            positive_reg  <= (margin > 34'sd0);
            margin_reg    <= margin[31:0];
            batch_end_reg <= req.batch_end;
        end
    end

    always_comb
    begin
        push_valid          = stage_valid_reg;
        push_data.on_label  = on_label_reg;
        push_data.positive  = positive_reg;
        push_data.margin    = margin_reg;
        push_data.weight    = weight_rd_reg;
        push_data.batch_end = batch_end_reg;
    end

endmodule

@@ rtl/dwhl_queue.sv @@
// Short first-in first-out queue of work items between front and back end.
// Depends on dwhl_pkg for the work item type and depth.
module dwhl_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  dwhl_pkg::work_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output dwhl_pkg::work_t pop_data
);
    import dwhl_pkg::*;

    work_t             q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = q_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (QPTR_W + 1)'(1);
        else if (pop && !push)
            count_next = count_reg - (QPTR_W + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= push_data;
    end

endmodule

@@ rtl/dwhl_back.sv @@
// Back end: a sequencer that turns one work item into cost, gradient and
// batch loss over several multiply steps, with the result register. Uses dwhl_pkg.
module dwhl_back (
    input  logic              clk,
    input  logic              rst_n,
    input  dwhl_pkg::cfg_t    cfg,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  dwhl_pkg::work_t   pop_data,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output dwhl_pkg::result_t rsp
);
    import dwhl_pkg::*;

    back_state_t        state_reg;
    back_state_t        state_next;
    work_t              work_reg;
    logic [63:0]        p_mm_reg;
    logic [49:0]        p_mw_reg;
    logic [49:0]        p_hw_reg;
    logic [33:0]        p_lw_reg;
    logic [50:0]        p_gh_reg;
    logic [47:0]        p_gl_reg;
    logic [47:0]        p_lh_reg;
    logic [32:0]        p_ll_reg;
    logic [30:0]        cost_reg;
    logic signed [31:0] grad_reg;
    logic [46:0]        cost_sum_reg;
    logic [46:0]        cost_sum_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    result_t            rsp_reg;

    logic               out_load;
    logic               gneg;
    logic [31:0]        gmag;
    logic [34:0]        base;
    logic [50:0]        cost_full;
    logic [30:0]        cost_sat;
    logic [51:0]        grad_mag;
    logic               grad_neg;
    logic signed [31:0] grad_sat;
    logic [47:0]        sum_full;
    logic [48:0]        loss_full;
    logic [46:0]        loss_sat;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: if (pop_valid) state_next = BK_MUL1;
            BK_MUL1: state_next = BK_MUL2;
            BK_MUL2: state_next = BK_COST;
            BK_COST: state_next = BK_SUM;
            BK_SUM:  state_next = BK_LOSS;
            BK_LOSS: state_next = BK_OUT;
            BK_OUT:  if (!rsp_valid_reg || rsp_ready) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        pop_ready = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            BK_IDLE: pop_ready = 1'b1;
            BK_OUT:  out_load  = !rsp_valid_reg || rsp_ready;
            default:
            begin
                pop_ready = 1'b0;
                out_load  = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        gneg = cfg.gradient_scale[31];
        gmag = gneg ? (~cfg.gradient_scale + 32'd1) : cfg.gradient_scale;

        // L2 base gradient is floor(2*w*m / 2^16), i.e. bits 49:15 of m*w.
        base = cfg.norm_mode ? p_mw_reg[49:15] : 35'(work_reg.weight);

        if (cfg.norm_mode)
            cost_full = 51'(p_hw_reg) + 51'(p_lw_reg[33:16]);
        else
            cost_full = 51'(p_mw_reg[49:16]);
        if (!work_reg.positive)
            cost_sat = '0;
        else if (cost_full > 51'h7FFF_FFFF)
            cost_sat = 31'h7FFF_FFFF;
        else
            cost_sat = cost_full[30:0];

        grad_mag = 52'(p_gh_reg) + 52'(p_gl_reg[47:16]);
        grad_neg = !work_reg.on_label ^ gneg;
        if (grad_neg)
            grad_sat = (grad_mag >= 52'h8000_0000) ? 32'sh8000_0000 : -grad_mag[31:0];
        else
            grad_sat = (grad_mag > 52'h7FFF_FFFF) ? 32'sh7FFF_FFFF : grad_mag[31:0];

        sum_full      = 48'(cost_sum_reg) + 48'(cost_reg);
        cost_sum_next = (sum_full > 48'h7FFF_FFFF_FFFF) ? 47'h7FFF_FFFF_FFFF
                                                         : sum_full[46:0];

        loss_full = 49'(p_lh_reg) + 49'(p_ll_reg[32:16]);
        loss_sat  = (loss_full > 49'h7FFF_FFFF_FFFF) ? 47'h7FFF_FFFF_FFFF
                                                      : loss_full[46:0];

        if (out_load)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            rsp_valid_reg <= 1'b0;
            cost_sum_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (state_reg == BK_SUM)
                cost_sum_reg <= cost_sum_next;
            else if (out_load && work_reg.batch_end)
                cost_sum_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
                if (pop_valid)
                    work_reg <= pop_data;
            BK_MUL1:
            begin
                p_mm_reg <= 64'(work_reg.margin) * 64'(work_reg.margin);
                p_mw_reg <= 50'(work_reg.margin) * 50'(work_reg.weight);
            end
            BK_MUL2:
            begin
                // The square is split into bits 63:32 and 31:16 so each multiplier operand stays at most 32 bits.
                p_hw_reg <= 50'(p_mm_reg[63:32]) * 50'(work_reg.weight);
                p_lw_reg <= 34'(p_mm_reg[31:16]) * 34'(work_reg.weight);
                p_gh_reg <= 51'(base[34:16]) * 51'(gmag);
                p_gl_reg <= 48'(base[15:0]) * 48'(gmag);
            end
            BK_COST:
            begin
                cost_reg <= cost_sat;
                grad_reg <= (work_reg.positive && cfg.gradient_on) ? grad_sat : '0;
            end
            BK_LOSS:
            begin
                p_lh_reg <= 48'(cost_sum_reg[46:16]) * 48'(cfg.loss_scale);
                p_ll_reg <= 33'(cost_sum_reg[15:0]) * 33'(cfg.loss_scale);
            end
            BK_OUT:
                if (out_load)
                begin
                    rsp_reg.element_cost     <= {1'b0, cost_reg};
                    rsp_reg.element_gradient <= grad_reg;
                    rsp_reg.batch_loss       <= work_reg.batch_end ? {1'b0, loss_sat} : '0;
                    rsp_reg.batch_done       <= work_reg.batch_end;
                end
            default:
                work_reg <= work_reg;
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ rtl/dwhl_checker.sv @@
// Port-level checks on the result channel of the hinge loss block, and the
// bind that attaches them to the top level. Depends on dwhl_pkg.
module dwhl_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input dwhl_pkg::result_t rsp
);
    import dwhl_pkg::*;

    // A result that is not taken stays, unchanged.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // Costs are clipped hinge values and never negative.
    a_cost_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !rsp.element_cost[31])
        else $error("negative element cost");

    // The batch loss is only shown on the item that closes a batch.
    a_loss_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.batch_done |-> rsp.batch_loss == '0)
        else $error("batch loss outside batch end");

    // The batch loss saturates below the top bit and is never negative.
    a_loss_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.batch_done |-> !rsp.batch_loss[47])
        else $error("negative batch loss");

endmodule

bind distance_weighted_hinge_loss dwhl_checker u_dwhl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

@@ tb/distance_weighted_hinge_loss_test.sv @@
// Self-checking testbench for the distance-weighted hinge loss block; depends on dwhl_pkg
// and the block's RTL. Drives weight loads, class scores and register writes, and checks
// every result against a cycle-free predictor of the block or a hand-typed result.
module distance_weighted_hinge_loss_test;

    import dwhl_pkg::*;

    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 104;

    // One row of the directed plan: a register write or an item, optionally with its
    // result typed in by hand.
    typedef struct packed {
        bit          is_write;
        cfg_idx_t    reg_idx;
        logic [31:0] reg_data;
        item_t       item;
        bit          has_known;
        result_t     known;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    item_t       req = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    result_t     rsp;

    // Predictor copy of the configuration and state, at reset values.
    bit               cfg_l2 = 1'b0;
    bit [4:0]         cfg_classes = 5'd16;
    logic signed [31:0] cfg_gscale = 32'sh0001_0000;
    bit [16:0]        cfg_lscale = 17'h1_0000;
    bit               cfg_grad_on = 1'b1;
    int unsigned      cls_pos = 0;
    bit [17:0]        dist_weight [16];
    bit [63:0]        cost_total = '0;

    result_t     results_due [$];
    plan_row_t   plan [$];
    result_t     want;
    int          error_count = 0;
    int          quiet_cycles = 0;
    bit          steady_sender = 1'b0;
    bit          valid_held = 1'b0;
    int          burst_left = 0;
    int unsigned rx_tick = 0;
    int unsigned rx_mode = 0;

    distance_weighted_hinge_loss u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int unsigned live_classes();
        if (cfg_classes < 2)
            return 2;
        if (cfg_classes > MAX_CLASSES)
            return MAX_CLASSES;
        return cfg_classes;
    endfunction

    // Base gradient times gradient_scale, truncated toward zero and saturated.
    function automatic longint scale_grad(input bit [63:0] base, input bit base_neg);
        bit        gneg;
        longint    gs;
        bit [63:0] gmag;
        bit [63:0] mag;
        gs = cfg_gscale;
        gneg = gs < 0;
        gmag = gneg ? -gs : gs;
        mag = (base >> 16) * gmag + (((base & 64'hFFFF) * gmag) >> 16);
        if (base_neg != gneg)
        begin
            if (mag >= 64'h8000_0000)
                return -longint'(64'h8000_0000);
            return -longint'(mag);
        end
        if (mag > 64'h7FFF_FFFF)
            return 64'h7FFF_FFFF;
        return mag;
    endfunction

    // Applies one accepted item to the predicted state; returns 1 when it yields a result.
    function automatic bit predict_item(input item_t it, output result_t r);
        int unsigned count;
        int unsigned pos;
        int unsigned class_dist;
        bit          on_label;
        longint      sc;
        longint      margin;
        longint      grad;
        bit [63:0]   m;
        bit [63:0]   w;
        bit [63:0]   cost;
        bit [63:0]   sq;
        bit [63:0]   base;
        bit [63:0]   loss;
        r = '0;
        if (it.opcode == OP_LOAD)
        begin
            dist_weight[it.weight_index] = it.weight_value;
            return 1'b0;
        end
        count = live_classes();
        if (cls_pos >= count)
            cls_pos = 0;
        pos = cls_pos;
        on_label = (pos == it.true_class);
        class_dist = (pos > it.true_class) ? pos - it.true_class : it.true_class - pos;
        w = dist_weight[class_dist % 16];
        sc = $signed(it.score);
        margin = on_label ? 65536 + sc : 65536 - sc;
        cost = '0;
        base = '0;
        grad = 0;
        if (margin > 0)
        begin
            m = margin;
            if (!cfg_l2)
            begin
                cost = (m * w) >> 16;
                base = w;
            end
            else
            begin
                sq = (m * m) >> 16;
                cost = (sq >> 16) * w + (((sq & 64'hFFFF) * w) >> 16);
                base = (2 * w * m) >> 16;
            end
            if (cost > 64'h7FFF_FFFF)
                cost = 64'h7FFF_FFFF;
            if (cfg_grad_on)
                grad = scale_grad(base, !on_label);
        end
        cost_total = cost_total + cost;
        if (cost_total > 64'h7FFF_FFFF_FFFF)
            cost_total = 64'h7FFF_FFFF_FFFF;
        loss = '0;
        if (it.batch_end)
        begin
            loss = (cost_total * cfg_lscale) >> 16;
            if (loss > 64'h7FFF_FFFF_FFFF)
                loss = 64'h7FFF_FFFF_FFFF;
            cost_total = '0;
            cls_pos = 0;
        end
        else
        begin
            cls_pos = (pos + 1 >= count) ? 0 : pos + 1;
        end
        r.element_cost = cost[31:0];
        r.element_gradient = grad[31:0];
        r.batch_loss = loss[47:0];
        r.batch_done = it.batch_end;
        return 1'b1;
    endfunction

    function automatic logic [31:0] random_score();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom;
            3: return ($urandom_range(0, 1) == 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            // Exactly one away from the label or the other side: margin of zero.
            4: return ($urandom_range(0, 1) == 1) ? 32'h0001_0000 : 32'hFFFF_0000;
            5, 6: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    function automatic void add_row(input logic op, input logic [31:0] score,
                                    input logic [3:0] true_cls, input logic [3:0] widx,
                                    input logic [17:0] wval, input logic last);
        plan_row_t row;
        row = '0;
        row.item.opcode = op;
        row.item.score = score;
        row.item.true_class = true_cls;
        row.item.weight_index = widx;
        row.item.weight_value = wval;
        row.item.batch_end = last;
        plan.push_back(row);
    endfunction

    // Marks the latest row with a hand-typed result that ends no batch.
    function automatic void add_known(input logic [31:0] cost, input logic [31:0] grad);
        plan[plan.size() - 1].has_known = 1'b1;
        plan[plan.size() - 1].known = '{cost, grad, 48'sd0, 1'b0};
    endfunction

    function automatic void add_write(input cfg_idx_t idx, input logic [31:0] data);
        plan_row_t row;
        row = '0;
        row.is_write = 1'b1;
        row.reg_idx = idx;
        row.reg_data = data;
        plan.push_back(row);
    endfunction

    // Called at a rising edge; returns at the edge where the item was accepted, or after
    // the gap that follows a burst.
    task automatic send_item(input item_t it, input bit has_known, input result_t known);
        result_t predicted;
        req <= it;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        if (predict_item(it, predicted))
            results_due.push_back(has_known ? known : predicted);
        if (steady_sender || burst_left > 0)
        begin
            valid_held = 1'b1;
            if (burst_left > 0)
                burst_left--;
        end
        else
        begin
            req_valid <= 1'b0;
            valid_held = 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    // Waits until the block has nothing left in flight.
    task automatic settle_idle();
        if (valid_held)
        begin
            req_valid <= 1'b0;
            valid_held = 1'b0;
        end
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write of a group.
    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_NORM_MODE:  cfg_l2 = data[0];
            CFG_CLASSES:    cfg_classes = data[4:0];
            CFG_GRAD_SCALE: cfg_gscale = data;
            CFG_LOSS_SCALE: cfg_lscale = data[16:0];
            CFG_GRAD_ON:    cfg_grad_on = data[0];
            default: ;
        endcase
    endtask

    task automatic program_phase(input int phase);
        logic [31:0] junk;
        logic        norm;
        logic [4:0]  classes;
        logic [31:0] gs;
        logic [16:0] ls;
        logic        gon;
        junk = '0;
        case (phase)
            0:
            begin
                norm = 1'b0;
                classes = 5'd2;
                gs = 32'h8000_0000;
                ls = 17'd0;
                gon = 1'b1;
            end
            1:
            begin
                norm = 1'b1;
                classes = 5'd16;
                gs = 32'h7FFF_FFFF;
                ls = 17'h1_0000;
                gon = 1'b1;
            end
            default:
            begin
                // Upper bits beyond a register's width must be dropped by the block.
                if ($urandom_range(0, 1) == 1)
                    junk = $urandom;
                norm = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 3) == 0)
                    classes = 5'($urandom_range(0, 31));
                else
                    classes = 5'($urandom_range(2, 16));
                case ($urandom_range(0, 3))
                    0: gs = $urandom;
                    1: gs = 32'h0001_0000;
                    default: gs = $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
                endcase
                if ($urandom_range(0, 3) == 0)
                    ls = 17'($urandom_range(0, 17'h1_FFFF));
                else
                    ls = 17'($urandom_range(0, 17'h1_0000));
                gon = ($urandom_range(0, 4) != 0);
            end
        endcase
        settle_idle();
        write_reg(CFG_NORM_MODE, {junk[31:1], norm});
        write_reg(CFG_CLASSES, {junk[31:5], classes});
        write_reg(CFG_GRAD_SCALE, gs);
        write_reg(CFG_LOSS_SCALE, {junk[31:17], ls});
        write_reg(CFG_GRAD_ON, {junk[31:1], gon});
        cfg_valid <= 1'b0;
    endtask

    // The receiver switches at random among five stall patterns, from always ready to random stalls.
    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 1;
        if (rx_tick % 256 == 0)
            rx_mode <= $urandom_range(0, 4);
        case (rx_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= (rx_tick % 4) != 3;
            2: rsp_ready <= (rx_tick % 2) == 0;
            3: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= (rx_tick % 23) < 14;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (results_due.size() == 0)
            begin
                $error("result arrived with no score item outstanding");
                error_count++;
            end
            else
            begin
                want = results_due.pop_front();
                if (rsp.element_cost !== want.element_cost)
                begin
                    $error("element_cost: expected %0d, got %0d",
                           $signed(want.element_cost), $signed(rsp.element_cost));
                    error_count++;
                end
                if (rsp.element_gradient !== want.element_gradient)
                begin
                    $error("element_gradient: expected %0d, got %0d",
                           $signed(want.element_gradient), $signed(rsp.element_gradient));
                    error_count++;
                end
                if (rsp.batch_loss !== want.batch_loss)
                begin
                    $error("batch_loss: expected %0d, got %0d",
                           $signed(want.batch_loss), $signed(rsp.batch_loss));
                    error_count++;
                end
                if (rsp.batch_done !== want.batch_done)
                begin
                    $error("batch_done: expected %0b, got %0b", want.batch_done, rsp.batch_done);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (cfg_valid && cfg_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int          phase;
        int          sent;
        int          k;
        int          span;
        int unsigned classes;
        logic [3:0]  true_cls;
        bit          finish_batch;
        item_t       it;

        // Every table entry is loaded before any score can read it.
        add_row(OP_LOAD, 32'h0000_0000, 4'd0, 4'd0, 18'h1_0000, 1'b0);
        add_row(OP_LOAD, 32'h0000_0000, 4'd0, 4'd1, 18'h3_FFFF, 1'b0);
        // A load ignores batch_end and its score fields.
        add_row(OP_LOAD, 32'hFFFF_FFFF, 4'd15, 4'd2, 18'h0_0000, 1'b1);
        add_row(OP_LOAD, 32'h0000_0000, 4'd0, 4'd3, 18'h0_C000, 1'b0);
        add_row(OP_LOAD, 32'h0000_0000, 4'd0, 4'd4, 18'h0_8000, 1'b0);
        add_row(OP_LOAD, 32'h0000_0000, 4'd0, 4'd5, 18'h1_4000, 1'b0);
        add_row(OP_LOAD, 32'h0000_0000, 4'd0, 4'd6, 18'h2_0000, 1'b0);
        add_row(OP_LOAD, 32'h0000_0000, 4'd0, 4'd7, 18'h0_0001, 1'b0);
        add_row(OP_LOAD, 32'h0000_0000, 4'd0, 4'd8, 18'h2_AAAA, 1'b0);
        add_row(OP_LOAD, 32'h0000_0000, 4'd0, 4'd9, 18'h1_5555, 1'b0);
        add_row(OP_LOAD, 32'h0000_0000, 4'd0, 4'd10, 18'h1_8000, 1'b0);
        add_row(OP_LOAD, 32'h0000_0000, 4'd0, 4'd11, 18'h0_4000, 1'b0);
        add_row(OP_LOAD, 32'h0000_0000, 4'd0, 4'd12, 18'h1_FFFF, 1'b0);
        add_row(OP_LOAD, 32'h0000_0000, 4'd0, 4'd13, 18'h3_0000, 1'b0);
        add_row(OP_LOAD, 32'h0000_0000, 4'd0, 4'd14, 18'h0_A3D7, 1'b0);
        add_row(OP_LOAD, 32'h0000_0000, 4'd0, 4'd15, 18'h2_4000, 1'b0);
        // Reset settings: L1, sixteen classes, unit scales, label class 0.
        add_row(OP_SCORE, 32'h0000_0000, 4'd0, 4'd0, 18'h0_0000, 1'b0);
        add_known(32'h0001_0000, 32'h0001_0000);
        add_row(OP_SCORE, 32'h8000_0000, 4'd0, 4'd15, 18'h3_FFFF, 1'b0);
        add_known(32'h7FFF_FFFF, 32'hFFFC_0001);
        add_row(OP_SCORE, 32'h7FFF_FFFF, 4'd0, 4'd0, 18'h0_0000, 1'b0);
        add_known(32'h0000_0000, 32'h0000_0000);
        add_row(OP_SCORE, 32'h0000_8000, 4'd0, 4'd0, 18'h0_0000, 1'b1);
        // A class count below two acts as two; the label then lies beyond the count.
        add_write(CFG_CLASSES, 32'd0);
        add_write(CFG_NORM_MODE, 32'd1);
        add_write(CFG_GRAD_SCALE, 32'h8000_0000);
        add_write(CFG_LOSS_SCALE, 32'h0001_FFFF);
        add_row(OP_SCORE, 32'h0000_4000, 4'd15, 4'd0, 18'h0_0000, 1'b0);
        add_row(OP_SCORE, 32'hFFFE_0000, 4'd15, 4'd0, 18'h0_0000, 1'b0);
        add_row(OP_SCORE, 32'h0000_C000, 4'd15, 4'd0, 18'h0_0000, 1'b1);
        // A class count above the maximum acts as the maximum; gradients switched off.
        add_write(CFG_CLASSES, 32'd31);
        add_write(CFG_NORM_MODE, 32'd0);
        add_write(CFG_GRAD_ON, 32'd0);
        add_write(CFG_GRAD_SCALE, 32'h7FFF_FFFF);
        add_row(OP_SCORE, 32'hFFFF_0000, 4'd15, 4'd0, 18'h0_0000, 1'b0);
        add_row(OP_SCORE, 32'h0001_0000, 4'd15, 4'd0, 18'h0_0000, 1'b1);
        // Squared hinge with the largest scale drives the gradient into both rails.
        add_write(CFG_GRAD_ON, 32'd1);
        add_write(CFG_NORM_MODE, 32'd1);
        add_write(CFG_CLASSES, 32'd16);
        add_write(CFG_LOSS_SCALE, 32'h0001_0000);
        add_row(OP_SCORE, 32'h7FFF_FFFF, 4'd0, 4'd0, 18'h0_0000, 1'b0);
        add_row(OP_SCORE, 32'h8000_0000, 4'd0, 4'd0, 18'h0_0000, 1'b0);
        add_row(OP_SCORE, 32'hFFFF_0000, 4'd0, 4'd0, 18'h0_0000, 1'b1);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_write)
            begin
                if (i == 0 || !plan[i - 1].is_write)
                    settle_idle();
                write_reg(plan[i].reg_idx, plan[i].reg_data);
                if (i == plan.size() - 1 || !plan[i + 1].is_write)
                    cfg_valid <= 1'b0;
            end
            else
            begin
                send_item(plan[i].item, plan[i].has_known, plan[i].known);
            end
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            program_phase(phase);
            steady_sender = (phase % 3 == 2);
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                // Mostly one whole sample per label; now and then a short or long one.
                classes = live_classes();
                if ($urandom_range(0, 9) == 0)
                    true_cls = 4'($urandom_range(0, 15));
                else
                    true_cls = 4'($urandom_range(0, classes - 1));
                if ($urandom_range(0, 7) == 0)
                    span = $urandom_range(1, classes + 2);
                else
                    span = classes;
                finish_batch = ($urandom_range(0, 2) == 0);
                for (k = 0; k < span; k++)
                begin
                    if ($urandom_range(0, 15) == 0)
                    begin
                        it.opcode = OP_LOAD;
                        it.score = $urandom;
                        it.true_class = 4'($urandom_range(0, 15));
                        it.weight_index = 4'($urandom_range(0, 15));
                        it.weight_value = 18'($urandom);
                        it.batch_end = 1'($urandom_range(0, 1));
                        send_item(it, 1'b0, '0);
                        sent++;
                    end
                    it.opcode = OP_SCORE;
                    it.score = random_score();
                    it.true_class = true_cls;
                    it.weight_index = 4'($urandom_range(0, 15));
                    it.weight_value = 18'($urandom);
                    if (k == span - 1)
                        it.batch_end = finish_batch;
                    else
                        it.batch_end = ($urandom_range(0, 49) == 0);
                    send_item(it, 1'b0, '0);
                    sent++;
                end
            end
        end

        settle_idle();
        if (error_count == 0 && results_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ distance_weighted_hinge_loss.f @@
rtl/dwhl_pkg.sv
rtl/dwhl_front.sv
rtl/dwhl_queue.sv
rtl/dwhl_back.sv
rtl/distance_weighted_hinge_loss.sv
rtl/dwhl_checker.sv
tb/distance_weighted_hinge_loss_test.sv
